/* design/assert_macros.svh */
// Assertion helpers shared by the design files.
// Every property is sampled on the rising clock edge and is disabled while
// the synchronous active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Holds a property at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds at any rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* design/mrrf_pkg.sv */
`timescale 1ns / 1ps

package mrrf_pkg;

    // Function codes carried in frame byte 1.
    localparam logic [7:0] FC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;

    // Quantity word of a read request.
    localparam logic [15:0] READ_QUANTITY = 16'h0001;

    // Request kinds on the input channel.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // CRC-16 parameters: reflected polynomial and preset.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDRESS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGISTER_ADDRESS = 2'd1;
    localparam int unsigned CFG_DATA_W = 16;

    // Byte positions within the eight-byte frame.
    localparam int unsigned POS_W = 3;
    localparam logic [POS_W-1:0] POS_SLAVE    = 3'd0;
    localparam logic [POS_W-1:0] POS_FUNC     = 3'd1;
    localparam logic [POS_W-1:0] POS_REG_HI   = 3'd2;
    localparam logic [POS_W-1:0] POS_REG_LO   = 3'd3;
    localparam logic [POS_W-1:0] POS_WORD_HI  = 3'd4;
    localparam logic [POS_W-1:0] POS_WORD_LO  = 3'd5;
    localparam logic [POS_W-1:0] POS_CRC_LO   = 3'd6;
    localparam logic [POS_W-1:0] POS_CRC_HI   = 3'd7;

    // Request queue between the front and the back.
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // One classified request.
    typedef struct packed {
        logic [7:0]  func;
        logic [15:0] word;
    } t_req;

    // Folds one byte into a running reflected CRC-16.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] acc;
        acc = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

endpackage

/* design/mrrf_front.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mrrf_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_kind,
    input  logic [15:0]     i_write_value,
    output logic            o_push,
    output mrrf_pkg::t_req  o_req,
    input  logic            i_full
);
    import mrrf_pkg::*;

    logic r_valid;
    t_req r_req;
    t_req n_req;
    logic push;
    logic take;

    // A request waits here only while the queue is full.
    assign push    = r_valid && !i_full;
    assign o_stall = r_valid && i_full;
    assign take    = i_valid && !o_stall;

    always_comb begin
        case (i_kind)
            KIND_READ: begin
                n_req.func = FC_READ_HOLDING;
                n_req.word = READ_QUANTITY;
            end
            default: begin
                n_req.func = FC_WRITE_SINGLE;
                n_req.word = i_write_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req <= n_req;
        end
    end

    assign o_push = push;
    assign o_req  = r_req;

    `ASSERT_AT(a_front_hold, i_clk, i_rst_n,
        (r_valid && i_full) |=> (r_valid && $stable(r_req)),
        "front request changed while the queue was full")

endmodule

/* design/mrrf_queue.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mrrf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mrrf_pkg::t_req  i_req,
    output logic            o_full,
    input  logic            i_pop,
    output mrrf_pkg::t_req  o_req,
    output logic            o_nonempty
);
    import mrrf_pkg::*;

    t_req              r_entry [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] ptr);
        return (ptr == QPTR_W'(QDEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign o_full     = (r_count == QCNT_W'(QDEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_req      = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_req;
        end
    end

    `ASSERT_NEVER(a_queue_overflow, i_clk, i_rst_n, i_push && o_full,
        "push into a full request queue")
    `ASSERT_NEVER(a_queue_underflow, i_clk, i_rst_n, i_pop && !o_nonempty,
        "pop from an empty request queue")
    `ASSERT_NEVER(a_queue_count, i_clk, i_rst_n, r_count > QCNT_W'(QDEPTH),
        "request queue count above its depth")

endmodule

/* design/mrrf_back.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mrrf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_slave_address,
    input  logic [15:0]     i_register_address,
    input  logic            i_nonempty,
    input  mrrf_pkg::t_req  i_req,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_frame_byte,
    output logic            o_last_byte
);
    import mrrf_pkg::*;

    logic             r_active;
    logic [POS_W-1:0] r_pos;
    t_req             r_req;
    logic [15:0]      r_crc;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    logic       slot_free;
    logic       adv;
    logic       finish;
    logic       pop;
    logic [7:0] cur_byte;

    // The output register is free when empty or when its byte leaves now.
    assign slot_free = !r_out_valid || !i_stall;
    assign adv       = r_active && slot_free;
    assign finish    = adv && (r_pos == POS_CRC_HI);
    assign pop       = i_nonempty && (!r_active || finish);

    always_comb begin
        unique case (r_pos)
            POS_SLAVE:   cur_byte = i_slave_address;
            POS_FUNC:    cur_byte = r_req.func;
            POS_REG_HI:  cur_byte = i_register_address[15:8];
            POS_REG_LO:  cur_byte = i_register_address[7:0];
            POS_WORD_HI: cur_byte = r_req.word[15:8];
            POS_WORD_LO: cur_byte = r_req.word[7:0];
            POS_CRC_LO:  cur_byte = r_crc[7:0];
            POS_CRC_HI:  cur_byte = r_crc[15:8];
            default:     cur_byte = r_crc[15:8];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_pos       <= POS_SLAVE;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_active <= 1'b1;
                r_pos    <= POS_SLAVE;
            end else if (finish) begin
                r_active <= 1'b0;
                r_pos    <= POS_SLAVE;
            end else if (adv) begin
                r_pos <= r_pos + 1'b1;
            end
            if (slot_free) begin
                r_out_valid <= r_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_req <= i_req;
            r_crc <= CRC_INIT;
        end else if (adv && (r_pos < POS_CRC_LO)) begin
            r_crc <= crc_byte(r_crc, cur_byte);
        end
        if (adv) begin
            r_out_byte <= cur_byte;
            r_out_last <= (r_pos == POS_CRC_HI);
        end
    end

    assign o_pop        = pop;
    assign o_valid      = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_last_byte  = r_out_last;

    `ASSERT_AT(a_back_idle_pos, i_clk, i_rst_n, !r_active |-> (r_pos == POS_SLAVE),
        "byte position not at frame start while idle")
    `ASSERT_AT(a_back_last_flag, i_clk, i_rst_n,
        (adv && (r_pos == POS_CRC_HI)) |=> (r_out_valid && r_out_last),
        "last flag missing on the CRC high byte")

endmodule

/* design/modbus_rtu_request_framer_top.sv */
`timescale 1ns / 1ps

// Modbus RTU request framer.
// Input channel (i_valid / o_stall): one item is a request kind (0 = write
// single register, function 6; 1 = read one register, function 3) and a
// 16-bit write value that a read ignores. Output channel (o_valid / i_stall):
// each item becomes eight bytes in transmission order: slave address,
// function code, register address and data word (high bytes first), then a
// CRC-16 (reflected 0xA001, preset 0xFFFF) low byte first. o_last_byte marks
// the eighth byte. The slave and register addresses come from the write port
// (index 0 and 1); the user must change them only while no frame is in
// flight, as the block itself does not enforce this. An accepted item passes
// the input register, the request queue and the sequencer before its first
// byte is presented. The output byte register sends one byte per cycle while
// i_stall is low, and the CRC is folded in one byte per cycle as they go out.
// A two-entry request queue sits between the input stage and the byte
// sequencer, so up to three further items are taken while a frame is sent.
// When the receiver stalls, the current byte holds and the sequencer waits;
// once the queue is full and the input stage holds an item, o_stall rises.
// Reset empties all stages and sets both address registers to 1.
module modbus_rtu_request_framer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mrrf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mrrf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_kind,
    input  logic [15:0]                      i_write_value,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [7:0]                       o_frame_byte,
    output logic                             o_last_byte
);
    import mrrf_pkg::*;

    logic [7:0]  r_slave_address;
    logic [15:0] r_register_address;

    logic push;
    logic full;
    logic pop;
    logic nonempty;
    t_req front_req;
    t_req queue_req;

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address    <= 8'd1;
            r_register_address <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SLAVE_ADDRESS:    r_slave_address    <= i_cfg_data[7:0];
                CFG_REGISTER_ADDRESS: r_register_address <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Input stage: takes items and classifies them into function and word.
    mrrf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_write_value (i_write_value),
        .o_push        (push),
        .o_req         (front_req),
        .i_full        (full)
    );

    // Short request queue that decouples the input from the byte sequencer.
    mrrf_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_req      (front_req),
        .o_full     (full),
        .i_pop      (pop),
        .o_req      (queue_req),
        .o_nonempty (nonempty)
    );

    // Byte sequencer: emits the frame and builds the CRC on the way.
    mrrf_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_slave_address    (r_slave_address),
        .i_register_address (r_register_address),
        .i_nonempty         (nonempty),
        .i_req              (queue_req),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_frame_byte       (o_frame_byte),
        .o_last_byte        (o_last_byte)
    );

endmodule

/* bench/tb_modbus_rtu_request_framer_top.sv */
`timescale 1ns / 1ps

// Self-checking bench for the Modbus RTU request framer.
//
// Every request item that the block takes on its input channel is turned into
// eight expected frame bytes by a predictor in this file, which keeps its own
// copy of the slave and register addresses. Each byte that leaves the output
// channel is compared, field by field, with the oldest expected byte.
//
// The stimulus starts with a short directed table (extreme addresses and
// values, both request kinds, reads with a nonzero value, writes to register
// indexes that do not exist, and a slave address written with upper data bits
// set). Where the frame header can be read off directly it is typed into the
// table; the CRC bytes always come from the predictor. After that come several
// random phases, each with its own address setting.
//
// Both channels idle at random. One phase holds the output channel off for a
// long stretch while the input side keeps pushing items, so the block fills up
// and asserts o_stall; another phase pauses the input side until every
// expected byte has come back.
module tb_modbus_rtu_request_framer_top;

    import mrrf_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 5;
    // An item passes the input register, the request queue and the byte sequencer before its first byte is presented.
    localparam int TAIL_CYCLES     = 8;
    localparam int IDLE_LIMIT      = 2000;
    localparam int LONG_HOLD       = 80;
    localparam int RANDOM_PHASES   = 5;
    localparam int ITEMS_PER_PHASE = 67;
    localparam int MAX_REPORTS     = 10;

    // Register indexes that the port can carry but the block does not have.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // One line of the directed table: either a request item or a register
    // write. For a request, header holds frame bytes 0 to 5 when typed is set.
    typedef enum logic { ROW_REQUEST, ROW_CONFIG } t_row_op;

    typedef struct packed {
        t_row_op                op;
        logic                   kind;
        logic [15:0]            value;
        logic [CFG_IDX_W-1:0]   cfg_idx;
        logic                   typed;
        logic [47:0]            header;
    } t_directed_row;

    typedef struct packed {
        logic        typed;
        logic [47:0] header;
    } t_known_header;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_frame_byte;

    localparam int DIRECTED_COUNT = 25;

    localparam t_directed_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // Reset addresses: slave 1, register 1.
        '{ROW_REQUEST, KIND_READ,  16'h0000, CFG_SLAVE_ADDRESS, 1'b1, 48'h01_03_00_01_00_01},
        '{ROW_REQUEST, KIND_WRITE, 16'h0000, CFG_SLAVE_ADDRESS, 1'b1, 48'h01_06_00_01_00_00},
        '{ROW_REQUEST, KIND_WRITE, 16'hFFFF, CFG_SLAVE_ADDRESS, 1'b1, 48'h01_06_00_01_FF_FF},
        '{ROW_REQUEST, KIND_READ,  16'hFFFF, CFG_SLAVE_ADDRESS, 1'b1, 48'h01_03_00_01_00_01},
        '{ROW_REQUEST, KIND_WRITE, 16'h1234, CFG_SLAVE_ADDRESS, 1'b1, 48'h01_06_00_01_12_34},
        '{ROW_REQUEST, KIND_WRITE, 16'h8001, CFG_SLAVE_ADDRESS, 1'b0, 48'h0},
        // Largest addresses; the upper data byte of a slave write is dropped.
        '{ROW_CONFIG,  KIND_WRITE, 16'hABFF, CFG_SLAVE_ADDRESS,    1'b0, 48'h0},
        '{ROW_CONFIG,  KIND_WRITE, 16'hFFFF, CFG_REGISTER_ADDRESS, 1'b0, 48'h0},
        '{ROW_CONFIG,  KIND_WRITE, 16'h0000, CFG_SPARE_2,          1'b0, 48'h0},
        '{ROW_CONFIG,  KIND_WRITE, 16'h0000, CFG_SPARE_3,          1'b0, 48'h0},
        '{ROW_REQUEST, KIND_WRITE, 16'hFFFF, CFG_SLAVE_ADDRESS, 1'b1, 48'hFF_06_FF_FF_FF_FF},
        '{ROW_REQUEST, KIND_READ,  16'h5AA5, CFG_SLAVE_ADDRESS, 1'b1, 48'hFF_03_FF_FF_00_01},
        '{ROW_REQUEST, KIND_WRITE, 16'h00FF, CFG_SLAVE_ADDRESS, 1'b0, 48'h0},
        // Smallest addresses; writes to the spare indexes must change nothing.
        '{ROW_CONFIG,  KIND_WRITE, 16'h0000, CFG_SLAVE_ADDRESS,    1'b0, 48'h0},
        '{ROW_CONFIG,  KIND_WRITE, 16'h0000, CFG_REGISTER_ADDRESS, 1'b0, 48'h0},
        '{ROW_CONFIG,  KIND_WRITE, 16'hFFFF, CFG_SPARE_2,          1'b0, 48'h0},
        '{ROW_CONFIG,  KIND_WRITE, 16'hFFFF, CFG_SPARE_3,          1'b0, 48'h0},
        '{ROW_REQUEST, KIND_WRITE, 16'h0000, CFG_SLAVE_ADDRESS, 1'b1, 48'h00_06_00_00_00_00},
        '{ROW_REQUEST, KIND_READ,  16'h0000, CFG_SLAVE_ADDRESS, 1'b1, 48'h00_03_00_00_00_01},
        '{ROW_REQUEST, KIND_WRITE, 16'hFF00, CFG_SLAVE_ADDRESS, 1'b1, 48'h00_06_00_00_FF_00},
        // A mixed setting, checked against the predictor alone.
        '{ROW_CONFIG,  KIND_WRITE, 16'h0047, CFG_SLAVE_ADDRESS,    1'b0, 48'h0},
        '{ROW_CONFIG,  KIND_WRITE, 16'hA55A, CFG_REGISTER_ADDRESS, 1'b0, 48'h0},
        '{ROW_REQUEST, KIND_WRITE, 16'h7E81, CFG_SLAVE_ADDRESS, 1'b0, 48'h0},
        '{ROW_REQUEST, KIND_READ,  16'h0000, CFG_SLAVE_ADDRESS, 1'b0, 48'h0},
        '{ROW_REQUEST, KIND_WRITE, 16'h55AA, CFG_SLAVE_ADDRESS, 1'b0, 48'h0}
    };

    // Every input of the block has a known value from the first instant.
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = CFG_SLAVE_ADDRESS;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_valid       = 1'b0;
    logic                  i_kind        = KIND_WRITE;
    logic [15:0]           i_write_value = '0;
    logic                  i_stall       = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic [7:0]            o_frame_byte;
    logic                  o_last_byte;

    // Shadow copies of the two address registers, used by the predictor.
    logic [7:0]  shadow_slave_address    = 8'd1;
    logic [15:0] shadow_register_address = 16'd1;

    t_frame_byte   frame_bytes_due[$];
    t_known_header known_headers[$];

    int mismatch_count     = 0;
    int requests_accepted  = 0;
    int reads_accepted     = 0;
    int bytes_checked      = 0;
    int frames_checked     = 0;
    int register_writes    = 0;
    int backpressure_seen  = 0;
    int idle_cycles        = 0;
    int burst_left         = 0;
    bit long_hold_req      = 1'b0;

    modbus_rtu_request_framer_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_write_value (i_write_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_frame_byte  (o_frame_byte),
        .o_last_byte   (o_last_byte)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Reflected CRC-16 over the six header bytes, most significant byte of
    // the vector first, as the bytes go out on the line.
    function automatic logic [15:0] header_crc16(input logic [47:0] header);
        logic [15:0] acc;
        acc = CRC_INIT;
        for (int p = 0; p < 6; p++) begin
            acc = acc ^ {8'h00, header[47 - 8 * p -: 8]};
            for (int b = 0; b < 8; b++) begin
                acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
            end
        end
        return acc;
    endfunction

    // Builds the whole eight-byte frame for one request from the shadow
    // addresses. A read always carries a quantity of one.
    function automatic logic [63:0] build_request_frame(input logic kind,
                                                        input logic [15:0] value);
        logic [47:0] header;
        logic [15:0] crc;
        header = {shadow_slave_address,
                  (kind == KIND_READ) ? FC_READ_HOLDING : FC_WRITE_SINGLE,
                  shadow_register_address,
                  (kind == KIND_READ) ? READ_QUANTITY : value};
        crc = header_crc16(header);
        return {header, crc[7:0], crc[15:8]};
    endfunction

    task automatic report_failure(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t ns: %s", $realtime, what);
        end
    endtask

    // Input side: every item taken turns into eight expected bytes. A header
    // typed into the directed table takes the place of the predicted one.
    always @(posedge i_clk) begin
        t_known_header known;
        logic [63:0]   frame;
        t_frame_byte   entry;
        if (i_rst_n && i_valid && !o_stall) begin
            known = '0;
            if (known_headers.size() != 0) begin
                known = known_headers.pop_front();
            end
            frame = build_request_frame(i_kind, i_write_value);
            if (known.typed) begin
                frame[63:16] = known.header;
            end
            for (int k = 0; k < 8; k++) begin
                entry.frame_byte = frame[63 - 8 * k -: 8];
                entry.last_byte  = (k == 7);
                frame_bytes_due.push_back(entry);
            end
            requests_accepted++;
            if (i_kind == KIND_READ) begin
                reads_accepted++;
            end
        end
        if (i_rst_n && i_valid && o_stall) begin
            backpressure_seen++;
        end
    end

    // Output side: each byte taken is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_frame_byte due;
        if (i_rst_n && o_valid && !i_stall) begin
            if (frame_bytes_due.size() == 0) begin
                report_failure($sformatf("unexpected byte %02h (last %0b), nothing pending",
                                         o_frame_byte, o_last_byte));
            end else begin
                due = frame_bytes_due.pop_front();
                if (o_frame_byte !== due.frame_byte || o_last_byte !== due.last_byte) begin
                    report_failure($sformatf({"byte mismatch: expected %02h last %0b, ",
                                              "got %02h last %0b"},
                                             due.frame_byte, due.last_byte,
                                             o_frame_byte, o_last_byte));
                end
            end
            bytes_checked++;
            if (o_last_byte === 1'b1) begin
                frames_checked++;
            end
        end
    end

    // The run is stopped if neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles, %0d bytes still pending",
                     IDLE_LIMIT, frame_bytes_due.size());
            $display("[modbus_rtu_request_framer_top] ERROR");
            $finish;
        end
    end

    // Output receiver. Each segment sets i_stall once and keeps it for a
    // random number of cycles. Short segments are the rule; long stalls and
    // long stall-free stretches both occur. A long hold-off is taken when the
    // sender asks for one.
    initial begin
        int pick;
        int span;
        bit level;
        forever begin
            @(posedge i_clk);
            pick = $urandom_range(0, 99);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                level = 1'b1;
                span  = LONG_HOLD;
            end else if (pick < 50) begin
                level = 1'b0;
                span  = $urandom_range(1, 4);
            end else if (pick < 75) begin
                level = 1'b1;
                span  = $urandom_range(1, 3);
            end else if (pick < 85) begin
                level = 1'b0;
                span  = $urandom_range(20, 50);
            end else if (pick < 95) begin
                level = 1'b1;
                span  = $urandom_range(4, 10);
            end else begin
                level = 1'b1;
                span  = $urandom_range(15, 30);
            end
            i_stall <= level;
            repeat (span - 1) @(posedge i_clk);
        end
    end

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_sender_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            return 0;
        end else if (pick < 80) begin
            return $urandom_range(1, 3);
        end else if (pick < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(15, 30);
    endfunction

    // Offers one request item and holds it until the block takes it. Called
    // and returning at a rising edge. When the next item follows with no gap,
    // i_valid simply stays high.
    task automatic offer_request(input logic kind, input logic [15:0] value,
                                 input logic typed, input logic [47:0] header);
        int gap;
        known_headers.push_back('{typed: typed, header: header});
        i_kind        <= kind;
        i_write_value <= value;
        i_valid       <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            gap = pick_sender_gap();
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops offering and waits until every expected byte has come back, so
    // no frame is in flight afterwards. The extra edge lets the input
    // monitor record an item taken at the edge this task was called on.
    task automatic wait_frames_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (frame_bytes_due.size() != 0) @(posedge i_clk);
    endtask

    // One register write; the shadow copy follows. Unknown indexes are
    // dropped by the block, so the shadow ignores them too.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SLAVE_ADDRESS:    shadow_slave_address    = data[7:0];
            CFG_REGISTER_ADDRESS: shadow_register_address = data;
            default: ;
        endcase
        register_writes++;
        @(posedge i_clk);
    endtask

    initial begin
        t_directed_row         row;
        logic [CFG_DATA_W-1:0] slave_data;
        logic [CFG_DATA_W-1:0] register_data;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Register writes wait until the block is idle.
        for (int r = 0; r < DIRECTED_COUNT; r++) begin
            row = DIRECTED_ROWS[r];
            if (row.op == ROW_CONFIG) begin
                wait_frames_drained();
                write_register(row.cfg_idx, row.value);
            end else begin
                offer_request(row.kind, row.value, row.typed, row.header);
            end
        end

        // Random phases. Phase 1 uses the largest addresses and phase 2 the
        // smallest; the others pick them at random.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_frames_drained();
            slave_data    = CFG_DATA_W'($urandom_range(0, 65535));
            register_data = CFG_DATA_W'($urandom_range(0, 65535));
            if (phase == 1) begin
                slave_data    = 16'hFFFF;
                register_data = 16'hFFFF;
            end else if (phase == 2) begin
                slave_data    = 16'h0000;
                register_data = 16'h0000;
            end
            if ($urandom_range(0, 1) == 1) begin
                write_register(CFG_REGISTER_ADDRESS, register_data);
                write_register(CFG_SLAVE_ADDRESS, slave_data);
            end else begin
                write_register(CFG_SLAVE_ADDRESS, slave_data);
                write_register(CFG_REGISTER_ADDRESS, register_data);
            end
            if ($urandom_range(0, 2) == 0) begin
                write_register($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                               CFG_DATA_W'($urandom_range(0, 65535)));
            end

            // The last phase offers items back to back throughout.
            if (phase == RANDOM_PHASES - 1) begin
                burst_left = ITEMS_PER_PHASE;
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Hold the receiver off for a long stretch while items keep
                // coming, so the internal queue fills and o_stall rises.
                if (phase == 2 && n == 20) begin
                    long_hold_req = 1'b1;
                    burst_left    = 14;
                end
                // Let the pipeline run dry in the middle of a phase.
                if (phase == 3 && n == 30) begin
                    wait_frames_drained();
                end
                offer_request(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                              1'b0, '0);
            end
        end

        wait_frames_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (frame_bytes_due.size() != 0) begin
            report_failure($sformatf("%0d expected bytes never arrived",
                                     frame_bytes_due.size()));
        end

        $display("Run covered %0d requests (%0d reads, %0d writes), %0d frames and %0d bytes.",
                 requests_accepted, reads_accepted, requests_accepted - reads_accepted,
                 frames_checked, bytes_checked);
        $display("%0d register writes; input held off by the block on %0d cycles; %0d mismatches.",
                 register_writes, backpressure_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("[modbus_rtu_request_framer_top] OK");
        end else begin
            $display("[modbus_rtu_request_framer_top] ERROR");
        end
        $finish;
    end

endmodule
